>>> sv/mf_pkg.sv
// ----------------------------------------------------------------------------
// mf_pkg
// Shared types, constants and the divide-by-nine helper of the 3x3 mean filter.
// ----------------------------------------------------------------------------
package mf_pkg;

  localparam int unsigned DATA_W     = 8;
  localparam int unsigned SUM_W      = 12;
  localparam int unsigned PROD_W     = 25;
  localparam int unsigned WIN_ROWS   = 3;
  localparam int unsigned LINE_BUFS  = 3;
  localparam int unsigned MAX_HEIGHT = 4096;

  localparam logic [12:0]      DIV9_MUL   = 13'd7281;
  localparam logic [SUM_W-1:0] DIV9_BIAS  = 12'd5;
  localparam int unsigned      DIV9_SHIFT = 16;

  localparam logic [1:0] CFG_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_CHANNELS = 2'd2;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_DRAIN  = 1'b1;

  // One step of the window pipeline.
  typedef struct packed {
    logic              emit;        // step produces a result
    logic              held;        // window taken from history only
    logic              left;        // clamp left neighbor to center
    logic              top_is_mid;  // replicate middle row upward
    logic              bot_is_mid;  // replicate middle row downward
    logic              eof;         // last result of the frame
    logic [DATA_W-1:0] sample;
  } step_t;

  function automatic logic [DATA_W-1:0] div9(input logic [SUM_W-1:0] sum);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(sum + DIV9_BIAS) * PROD_W'(DIV9_MUL);
    return prod[DIV9_SHIFT +: DATA_W];
  endfunction

endpackage

>>> sv/mean_filter_3x3.sv
// ----------------------------------------------------------------------------
// mean_filter_3x3
// Streaming 3x3 box filter with replicated border over interleaved images.
// ----------------------------------------------------------------------------
// One channel byte is taken per clock while s_tready is high, and each accepted
// transaction yields at most one result; results trail the input by one row and
// one pixel, plus a three-register pipeline (row buffer read, nine-tap sum, divide by nine).
// After the last sample, drain transactions (tuser set) release the held
// pixels and the last row one result each, the final one flagged by tlast.
// For a one-row frame the drain first re-reads the first pixel of the row
// buffer, holding s_tready low meanwhile. Row buffers are three
// MAX_WIDTH*MAX_CHANNELS byte RAMs with one write and one read per cycle; they
// need no clearing after reset. A write to width, height or channels restarts the frame.
// ----------------------------------------------------------------------------
module mean_filter_3x3
  import mf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,   // [7:0] sample
  input  logic              s_tuser,   // [0] kind
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DATA_W-1:0] m_tdata,   // [7:0] filtered
  output logic              m_tuser,   // [0] last_of_run
  output logic              m_tlast,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data
);

  localparam int unsigned LINE_DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW         = $clog2(LINE_DEPTH);
  localparam int unsigned SW         = $clog2(LINE_DEPTH + 1);
  localparam int unsigned DW         = $clog2(LINE_DEPTH + MAX_CHANNELS);
  localparam int unsigned WW         = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CHW        = $clog2(MAX_CHANNELS + 1);

  logic [12:0]       image_width;
  logic [12:0]       image_height;
  logic [2:0]        channel_count;
  logic [11:0]       row_count;
  logic [AW-1:0]     col_count;
  logic [DW-1:0]     drain_count;
  logic              draining;

  logic [WW-1:0]     eff_width;
  logic [12:0]       eff_height;
  logic [CHW-1:0]    eff_ch;
  logic [SW-1:0]     size;
  logic [SW-1:0]     col_w;
  logic [SW-1:0]     ch_w;
  logic [DW-1:0]     ch_d;
  logic              col_end;
  logic              last_row;
  logic              single_row;
  logic              prefetch;
  logic              drain_end;
  logic              accept;
  logic              is_sample;
  logic              do_row;
  logic              do_drain;
  logic              step_fire;
  logic              step_ready;
  step_t             step;
  logic [AW-1:0]     addr;
  logic [DATA_W-1:0] top_data;
  logic [DATA_W-1:0] mid_data;

  always_comb begin
    if (image_width < 13'd2) begin
      eff_width = WW'(2);
    end else if (int'(image_width) > MAX_WIDTH) begin
      eff_width = WW'(MAX_WIDTH);
    end else begin
      eff_width = WW'(image_width);
    end
    if (image_height == 13'd0) begin
      eff_height = 13'd1;
    end else if (int'(image_height) > MAX_HEIGHT) begin
      eff_height = 13'(MAX_HEIGHT);
    end else begin
      eff_height = image_height;
    end
    if (channel_count == 3'd0) begin
      eff_ch = CHW'(1);
    end else if (int'(channel_count) > MAX_CHANNELS) begin
      eff_ch = CHW'(MAX_CHANNELS);
    end else begin
      eff_ch = CHW'(channel_count);
    end
  end

  assign size       = SW'(eff_width) * SW'(eff_ch);
  assign col_w      = SW'(col_count);
  assign ch_w       = SW'(eff_ch);
  assign ch_d       = DW'(eff_ch);
  assign col_end    = col_w == size - SW'(1);
  assign last_row   = {1'b0, row_count} == eff_height - 13'd1;
  assign single_row = eff_height == 13'd1;
  assign prefetch   = draining && single_row && (drain_count < ch_d);
  assign drain_end  = drain_count == DW'(size) + ch_d - DW'(1);

  assign cfg_ready  = 1'b1;
  assign s_tready   = step_ready && !prefetch;
  assign accept     = s_tvalid && s_tready;
  assign is_sample  = s_tuser == KIND_SAMPLE;
  assign do_row     = accept && is_sample && !draining;
  assign do_drain   = draining && (prefetch ? step_ready : (accept && s_tuser == KIND_DRAIN));
  assign step_fire  = do_row || do_drain;
  assign addr       = draining ? drain_count[AW-1:0] : col_count;

  always_comb begin
    step.sample = s_tdata;
    if (draining) begin
      step.emit       = !single_row || (drain_count >= ch_d);
      step.held       = (drain_count < ch_d) || (drain_count >= DW'(size));
      step.left       = drain_count < (ch_d << 1);
      step.top_is_mid = single_row;
      step.bot_is_mid = 1'b1;
      step.eof        = drain_end;
    end else begin
      step.emit       = (row_count != 12'd0) && ((col_w >= ch_w) || (row_count > 12'd1));
      step.held       = col_w < ch_w;
      step.left       = col_w < (ch_w << 1);
      step.top_is_mid = row_count == 12'd1;
      step.bot_is_mid = 1'b0;
      step.eof        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= 13'd640;
      image_height  <= 13'd480;
      channel_count <= 3'd1;
      row_count     <= '0;
      col_count     <= '0;
      drain_count   <= '0;
      draining      <= 1'b0;
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index inside {CFG_WIDTH, CFG_HEIGHT, CFG_CHANNELS})) begin
      case (cfg_index)
        CFG_WIDTH:    image_width   <= cfg_data;
        CFG_HEIGHT:   image_height  <= cfg_data;
        CFG_CHANNELS: channel_count <= cfg_data[2:0];
        default:      image_width   <= image_width;
      endcase
      row_count   <= '0;
      col_count   <= '0;
      drain_count <= '0;
      draining    <= 1'b0;
    end else if (do_row) begin
      if (col_end) begin
        col_count <= '0;
        if (last_row) begin
          draining    <= 1'b1;
          drain_count <= '0;
        end else begin
          row_count <= row_count + 12'd1;
        end
      end else begin
        col_count <= col_count + AW'(1);
      end
    end else if (do_drain) begin
      if (drain_end) begin
        row_count   <= '0;
        col_count   <= '0;
        drain_count <= '0;
        draining    <= 1'b0;
      end else begin
        drain_count <= drain_count + DW'(1);
      end
    end
  end

  mf_linebuf #(
    .DEPTH (LINE_DEPTH)
  ) u_linebuf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (step_fire),
    .addr     (addr),
    .wr_en    (do_row),
    .wr_data  (s_tdata),
    .rotate   (do_row && col_end),
    .top_data (top_data),
    .mid_data (mid_data)
  );

  mf_window #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_window (
    .clk        (clk),
    .rst        (rst),
    .step_valid (step_fire),
    .step_ready (step_ready),
    .step       (step),
    .top_data   (top_data),
    .mid_data   (mid_data),
    .ch         (eff_ch),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

`ifndef SYNTHESIS
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    !draining |-> col_w < size)
    else $error("column counter beyond row size");

  a_row_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, row_count} < eff_height)
    else $error("row counter beyond frame height");

  a_drain_range: assert property (@(posedge clk) disable iff (rst)
    draining |-> drain_count <= DW'(size) + ch_d - DW'(1))
    else $error("drain counter beyond last result");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (rst)
    draining && step_fire |-> !do_row)
    else $error("row buffer written while draining");
`endif

endmodule

>>> sv/mf_linebuf.sv
// ----------------------------------------------------------------------------
// mf_linebuf
// Three rotating row buffers: one takes the incoming row, two are read back
// as the middle and top rows of the window. Read data is registered.
// ----------------------------------------------------------------------------
module mf_linebuf
  import mf_pkg::*;
#(
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     wr_en,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rotate,
  output logic [DATA_W-1:0]        top_data,
  output logic [DATA_W-1:0]        mid_data
);

  logic [1:0]        cur_sel;
  logic [1:0]        rd_sel;
  logic [DATA_W-1:0] rd_q [LINE_BUFS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sel <= 2'd0;
    end else if (rotate) begin
      cur_sel <= (cur_sel == 2'(LINE_BUFS - 1)) ? 2'd0 : cur_sel + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sel <= cur_sel;
    end
  end

  for (genvar i = 0; i < LINE_BUFS; i++) begin : g_row
    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en && cur_sel == 2'(i)) begin
        mem[addr] <= wr_data;
      end
      if (rd_en) begin
        rd_q[i] <= mem[addr];
      end
    end
  end

  always_comb begin
    mid_data = (rd_sel == 2'd0) ? rd_q[LINE_BUFS-1] : rd_q[rd_sel - 2'd1];
    top_data = (rd_sel == 2'(LINE_BUFS - 1)) ? rd_q[0] : rd_q[rd_sel + 2'd1];
  end

endmodule

>>> sv/mf_window.sv
// ----------------------------------------------------------------------------
// mf_window
// Column history, nine-tap sum and divide by nine, with the output register.
// Each row keeps two delay lines of channel_count bytes for the left columns.
// ----------------------------------------------------------------------------
module mf_window
  import mf_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 step_valid,
  output logic                                 step_ready,
  input  step_t                                step,
  input  logic [DATA_W-1:0]                    top_data,
  input  logic [DATA_W-1:0]                    mid_data,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]    ch,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [DATA_W-1:0]                    m_tdata,   // [7:0] filtered
  output logic                                 m_tuser,   // [0] last_of_run
  output logic                                 m_tlast
);

  logic              s1_valid;
  step_t             s1;
  logic              s2_valid;
  logic [SUM_W-1:0]  s2_sum;
  logic              s2_eof;
  logic              en_out;
  logic              en2;
  logic              en1;
  logic              shift;
  logic [DATA_W-1:0] col  [WIN_ROWS];
  logic [DATA_W-1:0] near [WIN_ROWS][MAX_CHANNELS];
  logic [DATA_W-1:0] far  [WIN_ROWS][MAX_CHANNELS];
  logic [SUM_W-1:0]  win_sum;

  assign en_out     = !m_tvalid || m_tready;
  assign en2        = !s2_valid || en_out;
  assign en1        = !s1_valid || en2;
  assign step_ready = en1;
  assign shift      = s1_valid && en2;
  assign m_tuser    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) begin
        s1_valid <= step_valid;
      end
      if (en2) begin
        s2_valid <= s1_valid && s1.emit;
      end
      if (en_out) begin
        m_tvalid <= s2_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && step_valid) begin
      s1 <= step;
    end
    if (en2 && s1_valid) begin
      s2_sum <= win_sum;
      s2_eof <= s1.eof;
    end
    if (en_out && s2_valid) begin
      m_tdata <= div9(s2_sum);
      m_tlast <= s2_eof;
    end
  end

  always_comb begin
    col[0] = s1.top_is_mid ? mid_data : top_data;
    col[1] = mid_data;
    col[2] = s1.bot_is_mid ? mid_data : s1.sample;
  end

  // Inject at depth ch, read at the head: near is ch columns back, far 2*ch.
  always_ff @(posedge clk) begin
    if (shift) begin
      for (int r = 0; r < WIN_ROWS; r++) begin
        for (int j = 0; j < MAX_CHANNELS; j++) begin
          near[r][j] <= (j == int'(ch) - 1) ? col[r] : near[r][(j + 1) % MAX_CHANNELS];
          far[r][j]  <= (j == int'(ch) - 1) ? near[r][0] : far[r][(j + 1) % MAX_CHANNELS];
        end
      end
    end
  end

  always_comb begin
    logic [DATA_W-1:0] a_v;
    logic [DATA_W-1:0] p_v;
    logic [DATA_W-1:0] b_v;
    win_sum = '0;
    for (int r = 0; r < WIN_ROWS; r++) begin
      a_v = (s1.left && !s1.held) ? near[r][0] : far[r][0];
      p_v = near[r][0];
      b_v = s1.held ? near[r][0] : col[r];
      win_sum = win_sum + SUM_W'(a_v) + SUM_W'(p_v) + SUM_W'(b_v);
    end
  end

endmodule

>>> sim/mf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mf_checker
// Watches the sample, result and register channels of the 3x3 mean filter and
// compares every result transaction against its own prediction of the filter.
// The predictor keeps three row buffers, the frame counters and the results
// held back at each row end. Predicted results wait in order, and each result
// transaction is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module mf_checker
  import mf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [DATA_W-1:0] s_tdata,
  input  logic              s_tuser,
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [DATA_W-1:0] m_tdata,
  input  logic              m_tuser,
  input  logic              m_tlast,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [12:0]       cfg_data,
  output int                mismatches,
  output int                outstanding,
  output int                checked
);

  localparam int unsigned LINE_DEPTH  = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned ROUND_BIAS  = 5;
  localparam int unsigned RECIP_NINE  = 7281;
  localparam int unsigned RECIP_SHIFT = 16;

  typedef enum logic [1:0] {ROW_OLDER, ROW_PREV, ROW_CUR} row_sel_t;

  typedef struct packed {
    logic [DATA_W-1:0] filtered;
    logic              last_of_run;
    logic              end_of_frame;
  } px_result_t;

  logic [DATA_W-1:0] older_row [LINE_DEPTH];
  logic [DATA_W-1:0] prev_row  [LINE_DEPTH];
  logic [DATA_W-1:0] cur_row   [LINE_DEPTH];
  logic [DATA_W-1:0] held_px   [MAX_CHANNELS];

  logic [12:0] reg_width;
  logic [12:0] reg_height;
  logic [2:0]  reg_chans;

  int unsigned row_idx;
  int unsigned col_idx;
  int unsigned drain_idx;
  int unsigned held_n;
  bit          draining;

  px_result_t expected_px [$];

  function automatic int unsigned clamp(input int unsigned v, input int unsigned lo,
                                        input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned chans();
    return clamp(reg_chans, 1, MAX_CHANNELS);
  endfunction

  function automatic int unsigned row_len();
    return clamp(reg_width, 2, MAX_WIDTH) * chans();
  endfunction

  function automatic int unsigned rows();
    return clamp(reg_height, 1, MAX_HEIGHT);
  endfunction

  function automatic logic [DATA_W-1:0] row_byte(input row_sel_t sel, input int unsigned idx);
    case (sel)
      ROW_OLDER: return older_row[idx];
      ROW_PREV:  return prev_row[idx];
      default:   return cur_row[idx];
    endcase
  endfunction

  // Rounded mean of the 3x3 window centered at row position p, edges replicated.
  function automatic logic [DATA_W-1:0] box_mean(input row_sel_t top, input row_sel_t mid,
                                                 input row_sel_t bot, input int unsigned p);
    int unsigned ch;
    int unsigned lft;
    int unsigned rgt;
    int unsigned sum;
    ch  = chans();
    lft = (p < ch) ? p : p - ch;
    rgt = (p + ch >= row_len()) ? p : p + ch;
    sum = row_byte(top, lft) + row_byte(top, p) + row_byte(top, rgt)
        + row_byte(mid, lft) + row_byte(mid, p) + row_byte(mid, rgt)
        + row_byte(bot, lft) + row_byte(bot, p) + row_byte(bot, rgt);
    return DATA_W'(((sum + ROUND_BIAS) * RECIP_NINE) >> RECIP_SHIFT);
  endfunction

  function automatic void restart_frame();
    row_idx   = 0;
    col_idx   = 0;
    drain_idx = 0;
    draining  = 1'b0;
    held_n    = 0;
  endfunction

  function automatic void write_reg(input logic [1:0] idx, input logic [12:0] val);
    case (idx)
      CFG_WIDTH:    reg_width  = val;
      CFG_HEIGHT:   reg_height = val;
      CFG_CHANNELS: reg_chans  = val[2:0];
      default:      return;
    endcase
    restart_frame();
  endfunction

  function automatic void push_result(input logic [DATA_W-1:0] val, input logic eof);
    px_result_t r;
    r.filtered     = val;
    r.last_of_run  = 1'b1;
    r.end_of_frame = eof;
    expected_px.push_back(r);
  endfunction

  function automatic void filter_step(input logic kind, input logic [DATA_W-1:0] smp);
    int unsigned ch;
    int unsigned len;
    int unsigned c;
    int unsigned k;
    row_sel_t    top;
    bit          eof;
    ch  = chans();
    len = row_len();
    if (kind == KIND_SAMPLE) begin
      c = col_idx;
      if (draining || c >= len) return;
      cur_row[c] = smp;
      top = (row_idx == 1) ? ROW_PREV : ROW_OLDER;
      if (row_idx >= 1) begin
        if (c >= ch) push_result(box_mean(top, ROW_PREV, ROW_CUR, c - ch), 1'b0);
        else if (c < held_n) push_result(held_px[c], 1'b0);
      end
      if (c == len - 1) begin
        held_n = 0;
        if (row_idx >= 1) begin
          for (int i = 0; i < ch; i++)
            held_px[i] = box_mean(top, ROW_PREV, ROW_CUR, len - ch + i);
          held_n = ch;
        end
        for (int i = 0; i < len; i++) begin
          older_row[i] = prev_row[i];
          prev_row[i]  = cur_row[i];
        end
        col_idx = 0;
        if (row_idx + 1 >= rows()) begin
          draining  = 1'b1;
          drain_idx = 0;
        end else begin
          row_idx++;
        end
      end else begin
        col_idx++;
      end
    end else if (draining) begin
      k = drain_idx;
      drain_idx++;
      eof = (drain_idx >= held_n + len);
      if (k < held_n) begin
        push_result(held_px[k], eof);
      end else begin
        top = (rows() == 1) ? ROW_PREV : ROW_OLDER;
        push_result(box_mean(top, ROW_PREV, ROW_PREV, k - held_n), eof);
      end
      if (eof) restart_frame();
    end
  endfunction

  always @(posedge clk) begin
    px_result_t want;
    if (rst) begin
      reg_width  = 13'd640;
      reg_height = 13'd480;
      reg_chans  = 3'd1;
      restart_frame();
      expected_px.delete();
      mismatches  = 0;
      checked     = 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) filter_step(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        if (expected_px.size() == 0) begin
          mismatches++;
          $display("%0t: result with none expected: filtered %0d last_of_run %0b end_of_frame %0b",
                   $time, m_tdata, m_tuser, m_tlast);
        end else begin
          want = expected_px.pop_front();
          checked++;
          if (m_tdata !== want.filtered) begin
            mismatches++;
            $display("%0t: filtered expected %0d actual %0d", $time, want.filtered, m_tdata);
          end
          if (m_tuser !== want.last_of_run) begin
            mismatches++;
            $display("%0t: last_of_run expected %0b actual %0b",
                     $time, want.last_of_run, m_tuser);
          end
          if (m_tlast !== want.end_of_frame) begin
            mismatches++;
            $display("%0t: end_of_frame expected %0b actual %0b",
                     $time, want.end_of_frame, m_tlast);
          end
        end
      end
      outstanding <= expected_px.size();
    end
  end

endmodule

>>> sim/tb_mean_filter_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mean_filter_3x3
// Stimulus and verdict for the streaming 3x3 mean filter.
// A short directed part covers extreme samples, ignored drain and sample
// transactions and a one-row multi-channel frame. Random frames follow with
// random sizes, out-of-range register values, stray transactions and frames
// cut short. Both stream sides stall at random; result checking lives in
// mf_checker.
// ----------------------------------------------------------------------------
module tb_mean_filter_3x3;
  import mf_pkg::*;

  localparam int unsigned MAX_WIDTH    = 4096;
  localparam int unsigned MAX_CHANNELS = 4;
  localparam int          RANDOM_ITEMS = 210;
  localparam int          QUIET_CYCLES = 16;
  localparam int          CYCLE_LIMIT  = 1000000;
  localparam int          NOISE_PCT    = 6;
  localparam logic [1:0]  CFG_SPARE    = 2'd3;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              s_tvalid  = 1'b0;
  logic              s_tready;
  logic [DATA_W-1:0] s_tdata   = '0;
  logic              s_tuser   = KIND_SAMPLE;
  logic              m_tvalid;
  logic              m_tready  = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = CFG_WIDTH;
  logic [12:0]       cfg_data  = '0;

  int mismatches;
  int outstanding;
  int checked;
  int cycle_cnt  = 0;
  int src_idle   = 0;
  int snk_idle   = 0;
  int eff_w;
  int eff_h;
  int eff_ch;
  int xfers      = 0;
  int frames     = 0;
  int setups     = 0;
  int aborts     = 0;

  always #6 clk = ~clk;

  mean_filter_3x3 #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mf_checker #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .checked     (checked)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= snk_idle);

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("mean_filter_3x3: mismatch");
      $finish;
    end
  end

  function automatic int clamp(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_byte();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return DATA_W'($urandom_range(255));
    endcase
  endfunction

  function automatic void set_stage(input int stage);
    case (stage)
      0:       begin src_idle = 9;  snk_idle = 62; end
      1:       begin src_idle = 62; snk_idle = 9;  end
      default: begin src_idle = 0;  snk_idle = 0;  end
    endcase
  endfunction

  task automatic send_item(input logic kind, input logic [DATA_W-1:0] smp);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= smp;
    do @(posedge clk); while (!s_tready);
    xfers++;
  endtask

  task automatic cfg_handshake();
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(input logic [12:0] w, input logic [12:0] h, input logic [2:0] ch,
                           input bit spare);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WIDTH;
    cfg_data  <= w;
    cfg_handshake();
    cfg_index <= CFG_HEIGHT;
    cfg_data  <= h;
    cfg_handshake();
    cfg_index <= CFG_CHANNELS;
    cfg_data  <= {10'd0, ch};
    cfg_handshake();
    if (spare) begin
      cfg_index <= CFG_SPARE;
      cfg_data  <= 13'($urandom_range(8191));
      cfg_handshake();
    end
    cfg_valid <= 1'b0;
    eff_w  = clamp(w, 2, MAX_WIDTH);
    eff_h  = clamp(h, 1, MAX_HEIGHT);
    eff_ch = clamp(ch, 1, MAX_CHANNELS);
    setups++;
  endtask

  // Wait out every expected result, then the pipeline tail.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // Feed one frame; an aborted frame stops at a random point before its end.
  task automatic run_frame(input bit abort, input int noise_pct, output int sent);
    int n_smp;
    int n_drn;
    int stop_at;
    n_smp   = eff_w * eff_ch * eff_h;
    n_drn   = (eff_h > 1 ? eff_ch : 0) + eff_w * eff_ch;
    stop_at = abort ? $urandom_range(1, n_smp + n_drn - 1) : n_smp + n_drn;
    sent    = 0;
    for (int i = 0; i < n_smp && sent < stop_at; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(KIND_DRAIN, pick_byte());
      send_item(KIND_SAMPLE, pick_byte());
      sent++;
    end
    for (int i = 0; i < n_drn && sent < stop_at; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(KIND_SAMPLE, pick_byte());
      send_item(KIND_DRAIN, pick_byte());
      sent++;
    end
    frames++;
  endtask

  initial begin
    int          done;
    int          n;
    int          reps;
    bit          abort;
    logic [12:0] w;
    logic [12:0] h;
    logic [2:0]  ch;
    done = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_stage(0);

    // 2x2 single channel: stray drain first, stray sample mid-drain, drain after frame end
    configure(13'd2, 13'd2, 3'd1, 1'b1);
    send_item(KIND_DRAIN, 8'hFF);
    send_item(KIND_SAMPLE, 8'h00);
    send_item(KIND_SAMPLE, 8'hFF);
    send_item(KIND_SAMPLE, 8'hFF);
    send_item(KIND_SAMPLE, 8'h00);
    send_item(KIND_DRAIN, 8'h00);
    send_item(KIND_SAMPLE, 8'hAA);
    send_item(KIND_DRAIN, 8'h55);
    send_item(KIND_DRAIN, 8'hFF);
    send_item(KIND_DRAIN, 8'h00);
    frames++;
    settle();
    // one row, two channels
    configure(13'd3, 13'd1, 3'd2, 1'b0);
    run_frame(1'b0, 0, n);
    settle();

    while (done < RANDOM_ITEMS) begin
      set_stage(done * 3 / RANDOM_ITEMS);
      w  = ($urandom_range(99) < 6) ? 13'($urandom_range(1)) : 13'($urandom_range(2, 7));
      h  = ($urandom_range(99) < 6) ? 13'd0 : 13'($urandom_range(1, 4));
      if ($urandom_range(99) < 10)
        ch = ($urandom_range(3) == 0) ? 3'd0 : 3'($urandom_range(5, 7));
      else
        ch = 3'($urandom_range(1, 4));
      configure(w, h, ch, $urandom_range(9) == 0);
      reps = $urandom_range(1, 2);
      for (int r = 0; r < reps; r++) begin
        abort = ($urandom_range(99) < 20);
        run_frame(abort, NOISE_PCT, n);
        done += n;
        if (abort) begin
          aborts++;
          break;
        end
        if ($urandom_range(3) == 0) send_item(KIND_DRAIN, pick_byte());
      end
      settle();
    end

    $display("Run covered %0d register setups and %0d frames (%0d cut short at random).",
             setups, frames, aborts);
    $display("%0d input transactions sent, %0d results compared.", xfers, checked);
    if (mismatches == 0 && outstanding == 0) begin
      $display("mean_filter_3x3: match");
    end else begin
      $display("mean_filter_3x3: mismatch");
    end
    $finish;
  end

endmodule
